// ===== hdl/imhq_pkg.sv =====
// Package of shared widths and codes for the indexed min-heap queue unit.
package imhq_pkg;
    localparam int HeapDepth  = 256;
    localparam int ItemCount  = 1024;
    localparam int WeightBits = 32;
    localparam int ItemW      = $clog2(ItemCount);
    localparam int SlotW      = $clog2(HeapDepth + 1);
    localparam int HAddrW     = $clog2(HeapDepth);

    typedef logic [1:0] t_code;
    localparam t_code OpInsert   = 2'd0;
    localparam t_code OpDecrease = 2'd1;
    localparam t_code OpPop      = 2'd2;

    localparam t_code StDone     = 2'd0;
    localparam t_code StEmpty    = 2'd1;
    localparam t_code StFull     = 2'd2;
    localparam t_code StAbsent   = 2'd3;
endpackage

// ===== hdl/indexed_min_heap_queue_unit.sv =====
// Top level of the indexed min-heap queue unit: sequencer around three memories.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-----------------------------------------------
//  request | i_valid | o_ready | i_operation, i_item, i_weight
//  result  | o_valid | i_ready | o_popped_item, o_status, o_count, o_is_empty
//
// One request is handled at a time. An insert climbs level by level from the
// new last slot, and may stop below the root; a decrease looks the item up in
// the position map and the slot memory first and then climbs the same way, or
// ends early when the item is absent. A pop descends level by level from the
// root, and may stop above a leaf.
// Each level costs serial registered reads of the slot memory and the weight memory.
// After reset a clearing pass zeroes all 1024 entries of the position map, and no
// request is taken during it. A result waits in the output register; the next
// request is taken while it waits, and the sequencer only stalls at the end of
// that request until it is taken.
module indexed_min_heap_queue_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic [9:0]                    i_item,
    input  logic [31:0]                   i_weight,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [9:0]                    o_popped_item,
    output logic [1:0]                    o_status,
    output logic [8:0]                    o_count,
    output logic                          o_is_empty
);
    localparam int IW = imhq_pkg::ItemW;
    localparam int SW = imhq_pkg::SlotW;
    localparam int AW = imhq_pkg::HAddrW;
    localparam int WB = imhq_pkg::WeightBits;

    // One-hot sequencer states.
    typedef enum logic [19:0] {
        S_CLR  = 20'h00001, S_IDLE = 20'h00002, S_INS  = 20'h00004,
        S_DEC0 = 20'h00008, S_DEC1 = 20'h00010, S_DEC2 = 20'h00020,
        S_POP0 = 20'h00040, S_POP1 = 20'h00080, S_POP2 = 20'h00100,
        S_POP3 = 20'h00200, S_UP   = 20'h00400, S_UP1  = 20'h00800,
        S_UP2  = 20'h01000, S_DN0  = 20'h02000, S_DN1  = 20'h04000,
        S_DN2  = 20'h08000, S_DN3  = 20'h10000, S_DN4  = 20'h20000,
        S_PUT  = 20'h40000, S_DONE = 20'h80000
    } t_state;

    t_state           r_state;
    logic [IW-1:0]    r_clr;
    logic [SW-1:0]    r_count;
    imhq_pkg::t_code  r_op;
    logic [IW-1:0]    r_item;
    logic [IW-1:0]    r_x;      // item being moved through the heap
    logic [WB-1:0]    r_w;      // its weight
    logic [IW-1:0]    r_pop;
    logic [SW-1:0]    r_k;      // hole position
    logic [SW-1:0]    r_m;      // entries covered by the sift down
    logic [IW-1:0]    r_c;      // candidate item
    logic [WB-1:0]    r_cw;
    logic [IW-1:0]    r_b;
    logic [SW:0]      r_ci;
    imhq_pkg::t_code  r_st;
    logic             r_ov;
    logic [IW-1:0]    r_o_pop;
    imhq_pkg::t_code  r_o_st;
    logic [SW-1:0]    r_o_cnt;

    // Heap slot memory, addressed by slot minus one.
    logic [IW-1:0] hp_mem [imhq_pkg::HeapDepth];
    logic          hp_we;
    logic [AW-1:0] hp_wa, hp_ra;
    logic [IW-1:0] hp_wd, hp_rd;
    // Position map, slot of each item.
    logic [SW-1:0] so_mem [imhq_pkg::ItemCount];
    logic          so_we;
    logic [IW-1:0] so_wa, so_ra;
    logic [SW-1:0] so_wd, so_rd;
    // Weight of each item.
    logic [WB-1:0] wt_mem [imhq_pkg::ItemCount];
    logic          wt_we;
    logic [IW-1:0] wt_wa, wt_ra;
    logic [WB-1:0] wt_wd, wt_rd;

    always_ff @(posedge i_clk) begin
        if (hp_we) begin
            hp_mem[hp_wa] <= hp_wd;
        end
        hp_rd <= hp_mem[hp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (so_we) begin
            so_mem[so_wa] <= so_wd;
        end
        so_rd <= so_mem[so_ra];
    end

    always_ff @(posedge i_clk) begin
        if (wt_we) begin
            wt_mem[wt_wa] <= wt_wd;
        end
        wt_rd <= wt_mem[wt_ra];
    end

    logic [SW:0] child;
    logic        has_right;
    logic [SW-1:0] k_less;

    assign child     = {r_k, 1'b0};
    assign has_right = child < {1'b0, r_m};
    assign k_less    = r_k - SW'(1);

    // Memory port control follows the state directly.
    always_comb begin
        hp_we = 1'b0; hp_wa = '0; hp_wd = '0; hp_ra = '0;
        so_we = 1'b0; so_wa = '0; so_wd = '0; so_ra = '0;
        wt_we = 1'b0; wt_wa = '0; wt_wd = '0; wt_ra = '0;
        case (r_state)
            S_CLR: begin
                so_we = 1'b1;
                so_wa = r_clr;
            end
            S_INS: begin
                wt_we = 1'b1; wt_wa = r_item; wt_wd = r_w;
            end
            S_DEC0: begin
                so_ra = r_item;
            end
            S_DEC1: begin
                hp_ra = AW'(so_rd - SW'(1));
            end
            S_DEC2: begin
                wt_we = (hp_rd == r_item);
                wt_wa = r_item; wt_wd = r_w;
            end
            S_POP0: begin
                hp_ra = '0;
            end
            S_POP1: begin
                hp_ra = AW'(r_count - SW'(1));
            end
            S_POP2: begin
                so_we = 1'b1; so_wa = r_pop; so_wd = r_count;
                wt_ra = hp_rd;
            end
            S_UP: begin
                hp_ra = AW'((r_k >> 1) - SW'(1));
            end
            S_UP1: begin
                wt_ra = hp_rd;
            end
            S_UP2: begin
                if (wt_rd > r_w) begin
                    hp_we = 1'b1; hp_wa = AW'(k_less); hp_wd = r_c;
                    so_we = 1'b1; so_wa = r_c; so_wd = r_k;
                end
            end
            S_DN0: begin
                hp_ra = AW'(child - (SW + 1)'(1));
            end
            S_DN1: begin
                wt_ra = hp_rd;
                hp_ra = AW'(child);
            end
            S_DN2: begin
                wt_ra = hp_rd;
            end
            S_DN4: begin
                if (r_w > r_cw) begin
                    hp_we = 1'b1; hp_wa = AW'(k_less); hp_wd = r_c;
                    so_we = 1'b1; so_wa = r_c; so_wd = r_k;
                end
            end
            S_PUT: begin
                hp_we = 1'b1; hp_wa = AW'(k_less); hp_wd = r_x;
                // A pop whose moved item is the popped item and never moved
                // keeps the map entry that the pop wrote for the last slot.
                so_we = !(r_op == imhq_pkg::OpPop && r_k == SW'(1) && r_x == r_pop);
                so_wa = r_x; so_wd = r_k;
            end
            default: begin
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            // The finishing state reloads the output register itself.
            if (r_ov && i_ready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + IW'(1);
                    if (r_clr == IW'(imhq_pkg::ItemCount - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op   <= i_operation;
                        r_item <= i_item;
                        r_x    <= i_item;
                        r_w    <= i_weight;
                        r_st   <= imhq_pkg::StDone;
                        case (i_operation)
                            imhq_pkg::OpInsert: begin
                                if (r_count >= SW'(imhq_pkg::HeapDepth)) begin
                                    r_st    <= imhq_pkg::StFull;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_INS;
                                end
                            end
                            imhq_pkg::OpDecrease: r_state <= S_DEC0;
                            imhq_pkg::OpPop: begin
                                if (r_count == '0) begin
                                    r_st    <= imhq_pkg::StEmpty;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_POP0;
                                end
                            end
                            default: begin
                                r_st    <= imhq_pkg::StAbsent;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_INS: begin
                    r_k     <= r_count + SW'(1);
                    r_count <= r_count + SW'(1);
                    r_state <= S_UP;
                end
                S_DEC0: r_state <= S_DEC1;
                S_DEC1: begin
                    r_k <= so_rd;
                    if (so_rd != '0 && so_rd <= r_count) begin
                        r_state <= S_DEC2;
                    end else begin
                        r_st    <= imhq_pkg::StAbsent;
                        r_state <= S_DONE;
                    end
                end
                S_DEC2: begin
                    if (hp_rd == r_item) begin
                        r_state <= S_UP;
                    end else begin
                        r_st    <= imhq_pkg::StAbsent;
                        r_state <= S_DONE;
                    end
                end
                S_POP0: r_state <= S_POP1;
                S_POP1: begin
                    r_pop   <= hp_rd;
                    r_state <= S_POP2;
                end
                S_POP2: begin
                    r_x     <= hp_rd;
                    r_state <= S_POP3;
                end
                S_POP3: begin
                    r_w     <= wt_rd;
                    r_m     <= r_count - SW'(1);
                    r_count <= r_count - SW'(1);
                    r_k     <= SW'(1);
                    r_state <= S_DN0;
                end
                S_UP: begin
                    r_state <= (r_k == SW'(1)) ? S_PUT : S_UP1;
                end
                S_UP1: begin
                    r_c     <= hp_rd;
                    r_state <= S_UP2;
                end
                S_UP2: begin
                    if (wt_rd > r_w) begin
                        r_k     <= r_k >> 1;
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_DN0: begin
                    r_state <= (child > {1'b0, r_m}) ? S_PUT : S_DN1;
                end
                S_DN1: begin
                    r_c     <= hp_rd;
                    r_ci    <= child;
                    r_state <= S_DN2;
                end
                S_DN2: begin
                    r_cw    <= wt_rd;
                    r_b     <= hp_rd;
                    r_state <= has_right ? S_DN3 : S_DN4;
                end
                S_DN3: begin
                    if (r_cw > wt_rd) begin
                        r_c  <= r_b;
                        r_cw <= wt_rd;
                        r_ci <= child + (SW + 1)'(1);
                    end
                    r_state <= S_DN4;
                end
                S_DN4: begin
                    if (r_w > r_cw) begin
                        r_k     <= SW'(r_ci);
                        r_state <= S_DN0;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: r_state <= S_DONE;
                S_DONE: begin
                    if (!r_ov || i_ready) begin
                        r_ov    <= 1'b1;
                        r_o_st  <= r_st;
                        r_o_cnt <= r_count;
                        r_o_pop <= (r_op == imhq_pkg::OpPop && r_st == imhq_pkg::StDone)
                                   ? r_pop : '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_popped_item = r_o_pop;
    assign o_status      = r_o_st;
    assign o_count       = r_o_cnt;
    assign o_is_empty    = (r_o_cnt == '0);
endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the indexed min-heap queue unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Holds a private copy of the heap, predicts one result per accepted request
    // and compares every result that the unit hands back.
    class heap_scoreboard;
        logic [9:0]  slots [1:imhq_pkg::HeapDepth];
        logic [8:0]  slot_of [imhq_pkg::ItemCount];
        logic [31:0] weight_of [imhq_pkg::ItemCount];
        int unsigned fill;
        logic [9:0]  want_item [$];
        logic [1:0]  want_status [$];
        logic [8:0]  want_count [$];
        logic        want_empty [$];
        int          errors;

        function new();
            for (int i = 0; i < imhq_pkg::ItemCount; i++) begin
                slot_of[i] = '0;
                weight_of[i] = '0;
            end
            for (int i = 1; i <= imhq_pkg::HeapDepth; i++) slots[i] = '0;
            fill = 0;
            errors = 0;
        endfunction

        function bit heavier(int unsigned a, int unsigned b);
            return weight_of[slots[a]] > weight_of[slots[b]];
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic [9:0] t;
            t = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
            slot_of[slots[a]] = a[8:0];
            slot_of[slots[b]] = b[8:0];
        endfunction

        function void climb(int unsigned k);
            while (k > 1 && heavier(k / 2, k)) begin
                swap_slots(k, k / 2);
                k = k / 2;
            end
        endfunction

        function void descend(int unsigned n);
            int unsigned k;
            int unsigned c;
            k = 1;
            while (2 * k <= n) begin
                c = 2 * k;
                if (c < n && heavier(c, c + 1)) c++;
                if (!heavier(k, c)) break;
                swap_slots(k, c);
                k = c;
            end
        endfunction

        // Applies one accepted request to the copy and queues its expected result.
        function void note_request(imhq_pkg::t_code op, logic [9:0] item, logic [31:0] w);
            logic [9:0]      popped;
            imhq_pkg::t_code st;
            int unsigned     s;
            popped = '0;
            st = imhq_pkg::StDone;
            if (op == imhq_pkg::OpInsert) begin
                if (fill >= imhq_pkg::HeapDepth) st = imhq_pkg::StFull;
                else begin
                    weight_of[item] = w;
                    fill++;
                    slots[fill] = item;
                    slot_of[item] = fill[8:0];
                    climb(fill);
                end
            end else if (op == imhq_pkg::OpDecrease) begin
                s = slot_of[item];
                if (s >= 1 && s <= fill && slots[s] == item) begin
                    weight_of[item] = w;
                    climb(s);
                end else st = imhq_pkg::StAbsent;
            end else if (op == imhq_pkg::OpPop) begin
                if (fill == 0) st = imhq_pkg::StEmpty;
                else begin
                    swap_slots(1, fill);
                    descend(fill - 1);
                    popped = slots[fill];
                    fill--;
                end
            end else st = imhq_pkg::StAbsent;
            want_item.push_back(popped);
            want_status.push_back(st);
            want_count.push_back(fill[8:0]);
            want_empty.push_back(fill == 0);
        endfunction

        function int pending();
            return want_item.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] exp);
            $display("mismatch on %s: got %0d, expected %0d", what, got, exp);
            errors++;
        endtask

        task check_result(logic [9:0] item, logic [1:0] st, logic [8:0] cnt, logic emp);
            if (want_item.size() == 0) begin
                report("unexpected result", 32'd1, 32'd0);
                return;
            end
            if (item !== want_item[0]) report("popped_item", 32'(item), 32'(want_item[0]));
            if (st !== want_status[0]) report("status", 32'(st), 32'(want_status[0]));
            if (cnt !== want_count[0]) report("count", 32'(cnt), 32'(want_count[0]));
            if (emp !== want_empty[0]) report("is_empty", 32'(emp), 32'(want_empty[0]));
            void'(want_item.pop_front());
            void'(want_status.pop_front());
            void'(want_count.pop_front());
            void'(want_empty.pop_front());
        endtask
    endclass

    // Watchdog: the limit on quiet cycles sits well above the clearing pass and
    // the slowest request, plus receiver stalls.
    localparam int QuietLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = imhq_pkg::OpInsert;
    logic [9:0]  i_item = '0;
    logic [31:0] i_weight = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [9:0]  o_popped_item;
    logic [1:0]  o_status;
    logic [8:0]  o_count;
    logic        o_is_empty;

    heap_scoreboard board = new();
    int  quiet_cycles = 0;
    int  burst_left = 0;
    // Items that the stimulus has inserted (pops do not remove them), so decreases
    // usually hit a live item.
    logic [9:0] live_items [$];

    indexed_min_heap_queue_unit u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Sample both channels at the rising edge: a request is noted in the
    // scoreboard when it is accepted, a result is checked when taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                board.note_request(imhq_pkg::t_code'(i_operation), i_item, i_weight);
            if (o_valid && i_ready)
                board.check_result(o_popped_item, o_status, o_count, o_is_empty);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= QuietLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver stalls on its own rhythm: long open stretches mixed with
    // phases of light and of heavy random backpressure.
    always @(negedge i_clk) begin
        int phase;
        phase = int'(($time / 12) % 600);
        if (phase < 150) i_ready <= 1'b1;
        else if (phase < 400) i_ready <= ($urandom_range(0, 3) != 0);
        else i_ready <= ($urandom_range(0, 3) == 0);
    end

    // Presents one request and holds it until accepted. The sender idles
    // between bursts, and never lowers valid when the next request follows.
    task automatic send_request(imhq_pkg::t_code op, logic [9:0] item, logic [31:0] w);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        i_operation <= op;
        i_item <= item;
        i_weight <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic do_insert(logic [9:0] item, logic [31:0] w);
        send_request(imhq_pkg::OpInsert, item, w);
        live_items.push_back(item);
    endtask

    task automatic do_pop();
        send_request(imhq_pkg::OpPop, 10'($urandom), $urandom);
    endtask

    initial begin
        logic [9:0] it;
        int         r;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: pop on empty, extremes of item and weight, equal
        // weights, decrease of a live item and of an absent one, duplicate
        // insert, larger-weight decrease and the unused operation code.
        do_pop();
        do_insert(10'd0, 32'hFFFF_FFFF);
        do_insert(10'd1023, 32'd0);
        do_insert(10'd512, 32'd7);
        do_insert(10'd513, 32'd7);
        send_request(imhq_pkg::OpDecrease, 10'd0, 32'd3);
        send_request(imhq_pkg::OpDecrease, 10'd300, 32'd1);
        do_insert(10'd512, 32'd2);
        send_request(imhq_pkg::OpDecrease, 10'd513, 32'hFFFF_FFF0);
        send_request(imhq_pkg::t_code'(2'd3), 10'h3FF, 32'hFFFF_FFFF);
        repeat (7) do_pop();
        live_items.delete();

        // Hold off until every result is back before the random part.
        drain_results();

        // Random part: churn with two fill phases toward full in between.
        for (int n = 0; n < 750; n++) begin
            if (n == 200 || n == 450) drain_results();
            r = $urandom_range(0, 99);
            if (n >= 120 && n < 420 && n % 300 < 260) begin
                // Fill phase presses against the 256-entry limit.
                if (r < 90) begin
                    it = 10'($urandom);
                    do_insert(it, pick_weight());
                end else if (r < 96 && live_items.size() != 0) begin
                    it = live_items[$urandom_range(0, live_items.size() - 1)];
                    send_request(imhq_pkg::OpDecrease, it,
                                 $urandom_range(0, 1) ? 32'd0 : $urandom);
                end else do_pop();
            end else if (r < 40) begin
                it = 10'($urandom);
                do_insert(it, pick_weight());
            end else if (r < 60 && live_items.size() != 0) begin
                it = live_items[$urandom_range(0, live_items.size() - 1)];
                send_request(imhq_pkg::OpDecrease, it, pick_weight());
            end else if (r < 65) begin
                send_request(imhq_pkg::OpDecrease, 10'($urandom), $urandom);
            end else if (r < 67) begin
                send_request(imhq_pkg::t_code'(2'd3), 10'($urandom), $urandom);
            end else begin
                do_pop();
            end
        end

        drain_results();
        repeat (100) @(negedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
